// ----- rtl/rppp_pkg.sv -----
package rppp_pkg;

  localparam int unsigned ZONES_DEFAULT      = 16;
  localparam int unsigned MAX_PACKET_DEFAULT = 512;

  localparam int unsigned ZONE_W  = 4;
  localparam int unsigned COLOR_W = 12;
  localparam int unsigned TDATA_W = 48;

  typedef enum logic {
    REQ_SRGB = 1'b0,
    REQ_DDP  = 1'b1
  } req_type_e;

  localparam logic [7:0] SRGB_START_ZERO = 8'd2;
  localparam logic [7:0] SRGB_START_ADDR = 8'd4;
  localparam logic [7:0] DDP_VER_MASK    = 8'hC0;
  localparam logic [7:0] DDP_VER_1       = 8'h40;
  localparam logic [7:0] DDP_TIMECODE    = 8'h10;

  localparam logic [3:0] HDR_LEN_NONE      = 4'd0;
  localparam logic [3:0] HDR_LEN_SRGB_ZERO = 4'd2;
  localparam logic [3:0] HDR_LEN_SRGB_ADDR = 4'd4;
  localparam logic [3:0] HDR_LEN_DDP       = 4'd10;
  localparam logic [3:0] HDR_LEN_DDP_TC    = 4'd14;

  localparam int unsigned SRGB_OFS_FIRST = 2;
  localparam int unsigned DDP_OFS_FIRST  = 4;
  localparam int unsigned DDP_OFS_LAST   = 7;

  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic               write_valid;
    logic [ZONE_W-1:0]  zone;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               packet_end;
    logic               frame_updated;
  } result_t;

  typedef logic [COLOR_W-1:0] gamma_lut_t [256];

  // g[v] = largest y with y^5 * 255^11 <= v^11 * 4095^5
  function automatic gamma_lut_t build_gamma();
    gamma_lut_t   lut;
    logic [159:0] p255;
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [11:0]  y;
    logic [11:0]  cand;
    int           v;
    int           k;
    int           b;
    p255 = 160'd1;
    for (k = 0; k < 11; k++) p255 = p255 * 160'd255;
    for (v = 0; v < 256; v++) begin
      rhs = 160'd1;
      for (k = 0; k < 5; k++) rhs = rhs * 160'd4095;
      for (k = 0; k < 11; k++) rhs = rhs * 160'(v);
      y = 12'd0;
      for (b = 11; b >= 0; b--) begin
        cand = y | (12'd1 << b);
        lhs  = p255;
        for (k = 0; k < 5; k++) lhs = lhs * 160'(cand);
        if (lhs <= rhs) y = cand;
      end
      lut[v] = y;
    end
    return lut;
  endfunction

endpackage

// ----- rtl/rppp_in_stage.sv -----
module rppp_in_stage
  import rppp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/rppp_core.sv -----
module rppp_core
  import rppp_pkg::*;
#(
  parameter int unsigned ZONES      = ZONES_DEFAULT,
  parameter int unsigned MAX_PACKET = MAX_PACKET_DEFAULT
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  item_t   item_i,
  input  logic    out_free_i,
  output logic    advance_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET + 1);
  localparam int unsigned NzW  = $clog2(ZONES + 1);
  localparam gamma_lut_t GammaLut = build_gamma();

  logic [PosW-1:0] pos_q, pos_d;
  logic            ok_q, ok_d;
  logic [3:0]      hl_q, hl_d;
  logic [31:0]     ofs_q, ofs_d;
  logic [31:0]     quot_q, quot_d;
  logic [1:0]      rem_q, rem_d;
  logic [NzW-1:0]  nz_q, nz_d;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      red_q, red_d;
  logic [7:0]      green_q, green_d;
  logic            any_q, any_d;

  logic            in_range;
  logic            is_first;
  logic [PosW-1:0] hl_ext;
  logic [PosW-1:0] hl_end;
  logic            in_hdr;
  logic            shift_en;
  logic            payload;
  logic            wrote;
  logic            has_result;
  logic [7:0]      b;
  logic [9:0]      div_x;
  logic [19:0]     div_prod;
  logic [7:0]      div_q;
  logic [9:0]      div_r;
  logic [31:0]     start_ofs;

  assign b        = item_i.data_byte;
  assign in_range = pos_q < PosW'(MAX_PACKET);
  assign is_first = pos_q == '0;
  assign hl_ext   = {{(PosW-4){1'b0}}, hl_q};
  assign in_hdr   = ok_q && !is_first && (pos_q < hl_ext);
  assign shift_en = in_hdr &&
                    (((hl_q == HDR_LEN_SRGB_ADDR) && (pos_q >= PosW'(SRGB_OFS_FIRST))) ||
                     ((hl_q >= HDR_LEN_DDP) && (pos_q >= PosW'(DDP_OFS_FIRST)) &&
                      (pos_q <= PosW'(DDP_OFS_LAST))));
  assign payload  = ok_q && !is_first && !in_hdr;

  // divide remainder-extended byte by 3
  assign div_x    = {rem_q, b};
  assign div_prod = 20'(div_x) * 20'd683;
  assign div_q    = div_prod[18:11];
  assign div_r    = div_x - {1'b0, div_q, 1'b0} - {2'b00, div_q};

  always_comb begin
    pos_d      = pos_q;
    ok_d       = ok_q;
    hl_d       = hl_q;
    ofs_d      = ofs_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    nz_d       = nz_q;
    phase_d    = phase_q;
    red_d      = red_q;
    green_d    = green_q;
    any_d      = any_q;
    wrote      = 1'b0;
    hl_end     = '0;
    start_ofs  = '0;
    if (in_range) begin
      if (is_first) begin
        if (item_i.req_type == REQ_SRGB) begin
          if (b == SRGB_START_ZERO) begin
            ok_d = 1'b1;
            hl_d = HDR_LEN_SRGB_ZERO;
          end else if (b == SRGB_START_ADDR) begin
            ok_d = 1'b1;
            hl_d = HDR_LEN_SRGB_ADDR;
          end else begin
            ok_d = 1'b0;
          end
        end else begin
          if ((b & DDP_VER_MASK) == DDP_VER_1) begin
            ok_d = 1'b1;
            hl_d = ((b & DDP_TIMECODE) != 8'd0) ? HDR_LEN_DDP_TC : HDR_LEN_DDP;
          end else begin
            ok_d = 1'b0;
          end
        end
        ofs_d  = '0;
        quot_d = '0;
        rem_d  = '0;
      end else if (shift_en) begin
        ofs_d  = {ofs_q[23:0], b};
        quot_d = {quot_q[23:0], div_q};
        rem_d  = div_r[1:0];
      end else if (payload) begin
        case (phase_q)
          2'd0: begin
            red_d   = b;
            phase_d = 2'd1;
          end
          2'd1: begin
            green_d = b;
            phase_d = 2'd2;
          end
          default: begin
            if (nz_q < NzW'(ZONES)) begin
              wrote = 1'b1;
              any_d = 1'b1;
              nz_d  = nz_q + NzW'(1);
            end
            phase_d = 2'd0;
          end
        endcase
      end
      hl_end = {{(PosW-4){1'b0}}, hl_d - 4'd1};
      if (ok_d && (hl_d != HDR_LEN_NONE) && (pos_q == hl_end)) begin
        start_ofs = (hl_d >= HDR_LEN_DDP) ? quot_d : ofs_d;
        nz_d      = (start_ofs >= 32'(ZONES)) ? NzW'(ZONES) : start_ofs[NzW-1:0];
        phase_d   = 2'd0;
      end
      pos_d = pos_q + PosW'(1);
    end
    if (item_i.last_byte) begin
      pos_d   = '0;
      ok_d    = 1'b0;
      hl_d    = HDR_LEN_NONE;
      ofs_d   = '0;
      quot_d  = '0;
      rem_d   = '0;
      nz_d    = '0;
      phase_d = 2'd0;
      red_d   = '0;
      green_d = '0;
      any_d   = 1'b0;
    end
  end

  assign has_result     = wrote || item_i.last_byte;
  assign advance_o      = valid_i && (!has_result || out_free_i);
  assign result_valid_o = advance_o && has_result;

  always_comb begin
    result_o               = '0;
    result_o.write_valid   = wrote;
    result_o.packet_end    = item_i.last_byte;
    result_o.frame_updated = item_i.last_byte && (any_q || wrote);
    if (wrote) begin
      result_o.zone  = ZONE_W'(nz_q);
      result_o.red   = GammaLut[red_q];
      result_o.green = GammaLut[green_q];
      result_o.blue  = GammaLut[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ok_q    <= 1'b0;
      hl_q    <= HDR_LEN_NONE;
      ofs_q   <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      nz_q    <= '0;
      phase_q <= 2'd0;
      red_q   <= '0;
      green_q <= '0;
      any_q   <= 1'b0;
    end else if (advance_o) begin
      pos_q   <= pos_d;
      ok_q    <= ok_d;
      hl_q    <= hl_d;
      ofs_q   <= ofs_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      nz_q    <= nz_d;
      phase_q <= phase_d;
      red_q   <= red_d;
      green_q <= green_d;
      any_q   <= any_d;
    end
  end

endmodule

// ----- rtl/rppp_out_stage.sv -----
module rppp_out_stage
  import rppp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t result_o,
  input  logic    ready_i
);

  logic    valid_q;
  result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && free_o) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- rtl/rgb_pixel_packet_parser.sv -----
// A byte accepted into the input register has its result captured in the result register.
// Throughput: one byte per cycle while the output stage can take results; per-packet state and
// the gamma lookup settle combinationally between the input register and the result register.
// Bytes that cause no result advance without waiting for the output side.
// Reset (rst_ni low, asynchronous) empties both stages and clears all packet state.
module rgb_pixel_packet_parser
  import rppp_pkg::*;
#(
  parameter int unsigned ZONES      = ZONES_DEFAULT,
  parameter int unsigned MAX_PACKET = MAX_PACKET_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // data_byte
  input  logic               s_axis_tuser_i,   // req_type
  input  logic               s_axis_tlast_i,   // last_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // zone, red, green, blue, frame_updated, zeros
  output logic               m_axis_tuser_o,   // write_valid
  output logic               m_axis_tlast_o    // packet_end
);

  item_t   s_item;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_item.req_type  = req_type_e'(s_axis_tuser_i);
  assign s_item.data_byte = s_axis_tdata_i;
  assign s_item.last_byte = s_axis_tlast_i;

  rppp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .item_i    (s_item),
    .ready_o   (s_axis_tready_o),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  rppp_core #(
    .ZONES      (ZONES),
    .MAX_PACKET (MAX_PACKET)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid),
    .item_i         (in_item),
    .out_free_i     (out_free),
    .advance_o      (advance),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  rppp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (res_valid),
    .result_i (res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_res),
    .ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {7'd0, out_res.frame_updated, out_res.blue, out_res.green,
                           out_res.red, out_res.zone};
  assign m_axis_tuser_o = out_res.write_valid;
  assign m_axis_tlast_o = out_res.packet_end;

endmodule
